// ===== rtl/core/wnm_pkg.sv =====
package wnm_pkg;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_MASK  = 2'd1,
        ACT_NAME  = 2'd2,
        ACT_MATCH = 2'd3
    } t_action;

    typedef struct packed {
        t_action    action;
        logic [7:0] ch;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_DONE
    } t_state;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_STAR     = 8'h2A;
    localparam logic [7:0] CH_QMARK    = 8'h3F;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_LOWER_A  = 8'h61;
    localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

endpackage

// ===== rtl/core/wnm_front.sv =====
module wnm_front (
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] char_code
    input  logic [1:0]            s_axis_tuser,   // [1:0] action
    input  wnm_pkg::t_queue_status i_status,
    output logic                  o_push,
    output wnm_pkg::t_cmd         o_cmd
);

    wnm_pkg::t_action action;
    logic             is_lower;

    assign action        = wnm_pkg::t_action'(s_axis_tuser);
    assign s_axis_tready = !i_status.full;
    assign o_push        = s_axis_tvalid && !i_status.full;
    assign is_lower      = (s_axis_tdata >= wnm_pkg::CH_LOWER_A) &&
                           (s_axis_tdata <= wnm_pkg::CH_LOWER_Z);

    // fold name characters to upper case, keep mask characters as given
    always_comb begin
        o_cmd.action = action;
        o_cmd.ch     = s_axis_tdata;
        if (action == wnm_pkg::ACT_NAME && is_lower) begin
            o_cmd.ch = s_axis_tdata - wnm_pkg::CASE_OFFSET;
        end
    end

endmodule

// ===== rtl/core/wnm_queue.sv =====
module wnm_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  wnm_pkg::t_cmd          i_cmd,
    input  logic                   i_pop,
    output wnm_pkg::t_cmd          o_cmd,
    output wnm_pkg::t_queue_status o_status
);

    wnm_pkg::t_cmd            r_slot [wnm_pkg::QUEUE_DEPTH];
    logic [wnm_pkg::QPW-1:0]  r_wr_ptr;
    logic [wnm_pkg::QPW-1:0]  r_rd_ptr;
    logic [wnm_pkg::QCW-1:0]  r_count;
    logic                     do_push;
    logic                     do_pop;

    assign o_status.full  = (r_count == wnm_pkg::QCW'(wnm_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_cmd          = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/wnm_back.sv =====
module wnm_back #(
    parameter int MAX_LEN = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  wnm_pkg::t_cmd          i_cmd,
    input  wnm_pkg::t_queue_status i_status,
    output logic                   o_pop,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [7:0]             m_axis_tdata    // [0] matched, [1] truncated
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int AW = $clog2(MAX_LEN);

    logic [7:0]        r_mask_mem [MAX_LEN];
    logic [7:0]        r_name_mem [MAX_LEN];
    logic [7:0]        r_rd_m;
    logic [7:0]        r_rd_m1;
    logic [7:0]        r_rd_n;

    wnm_pkg::t_state   r_state,     n_state;
    logic [LW-1:0]     r_mask_len,  n_mask_len;
    logic [LW-1:0]     r_name_len,  n_name_len;
    logic              r_ovf,       n_ovf;
    logic              r_mask_drop, n_mask_drop;
    logic              r_m0_star,   n_m0_star;
    logic              r_m1_dot,    n_m1_dot;
    logic              r_m2_star,   n_m2_star;
    logic              r_name_dot,  n_name_dot;
    logic [LW-1:0]     r_s,         n_s;
    logic [LW-1:0]     r_f,         n_f;
    logic [LW-1:0]     r_ls,        n_ls;
    logic [LW-1:0]     r_lf,        n_lf;
    logic              r_saved,     n_saved;
    logic              r_match,     n_match;
    logic              r_out_valid, n_out_valid;
    logic              r_out_match, n_out_match;
    logic              r_out_trunc, n_out_trunc;

    logic              mask_we;
    logic              name_we;
    logic [LW-1:0]     s_plus1;
    logic [LW-1:0]     f_plus1;
    logic              in_loop;

    assign s_plus1       = r_s + 1'b1;
    assign f_plus1       = r_f + 1'b1;
    assign in_loop       = (r_s < r_mask_len) && (r_f < r_name_len);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_trunc, r_out_match};

    always_ff @(posedge i_clk) begin
        if (mask_we) begin
            r_mask_mem[r_mask_len[AW-1:0]] <= i_cmd.ch;
        end
        if (name_we) begin
            r_name_mem[r_name_len[AW-1:0]] <= i_cmd.ch;
        end
        r_rd_m  <= r_mask_mem[r_s[AW-1:0]];
        r_rd_m1 <= r_mask_mem[s_plus1[AW-1:0]];
        r_rd_n  <= r_name_mem[r_f[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= wnm_pkg::ST_IDLE;
            r_mask_len  <= '0;
            r_name_len  <= '0;
            r_ovf       <= 1'b0;
            r_mask_drop <= 1'b0;
            r_name_dot  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mask_len  <= n_mask_len;
            r_name_len  <= n_name_len;
            r_ovf       <= n_ovf;
            r_mask_drop <= n_mask_drop;
            r_name_dot  <= n_name_dot;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m0_star   <= n_m0_star;
        r_m1_dot    <= n_m1_dot;
        r_m2_star   <= n_m2_star;
        r_s         <= n_s;
        r_f         <= n_f;
        r_ls        <= n_ls;
        r_lf        <= n_lf;
        r_saved     <= n_saved;
        r_match     <= n_match;
        r_out_match <= n_out_match;
        r_out_trunc <= n_out_trunc;
    end

    always_comb begin
        n_state     = r_state;
        n_mask_len  = r_mask_len;
        n_name_len  = r_name_len;
        n_ovf       = r_ovf;
        n_mask_drop = r_mask_drop;
        n_m0_star   = r_m0_star;
        n_m1_dot    = r_m1_dot;
        n_m2_star   = r_m2_star;
        n_name_dot  = r_name_dot;
        n_s         = r_s;
        n_f         = r_f;
        n_ls        = r_ls;
        n_lf        = r_lf;
        n_saved     = r_saved;
        n_match     = r_match;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_match = r_out_match;
        n_out_trunc = r_out_trunc;
        mask_we     = 1'b0;
        name_we     = 1'b0;
        o_pop       = 1'b0;

        unique case (r_state)
            wnm_pkg::ST_IDLE: begin
                if (!i_status.empty) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.action)
                        wnm_pkg::ACT_CLEAR: begin
                            n_mask_len  = '0;
                            n_ovf       = 1'b0;
                            n_mask_drop = 1'b0;
                        end
                        wnm_pkg::ACT_MASK: begin
                            if (r_mask_len < LW'(MAX_LEN)) begin
                                mask_we    = 1'b1;
                                n_mask_len = r_mask_len + 1'b1;
                                // track the first three characters for the shortcut masks
                                if (r_mask_len == LW'(0)) begin
                                    n_m0_star = (i_cmd.ch == wnm_pkg::CH_STAR);
                                end
                                if (r_mask_len == LW'(1)) begin
                                    n_m1_dot = (i_cmd.ch == wnm_pkg::CH_DOT);
                                end
                                if (r_mask_len == LW'(2)) begin
                                    n_m2_star = (i_cmd.ch == wnm_pkg::CH_STAR);
                                end
                            end else begin
                                n_ovf       = 1'b1;
                                n_mask_drop = 1'b1;
                            end
                        end
                        wnm_pkg::ACT_NAME: begin
                            if (r_name_len < LW'(MAX_LEN)) begin
                                name_we    = 1'b1;
                                n_name_len = r_name_len + 1'b1;
                                if (i_cmd.ch == wnm_pkg::CH_DOT) begin
                                    n_name_dot = 1'b1;
                                end
                            end else begin
                                n_ovf = 1'b1;
                            end
                        end
                        wnm_pkg::ACT_MATCH: begin
                            n_s     = '0;
                            n_f     = '0;
                            n_saved = 1'b0;
                            if (r_mask_len == '0) begin
                                n_match = 1'b1;
                                n_state = wnm_pkg::ST_DONE;
                            end else if (r_mask_len == LW'(3) && r_m0_star && r_m1_dot &&
                                         r_m2_star) begin
                                n_match = 1'b1;
                                n_state = wnm_pkg::ST_DONE;
                            end else if (r_mask_len == LW'(2) && r_m0_star && r_m1_dot) begin
                                n_match = !r_name_dot;
                                n_state = wnm_pkg::ST_DONE;
                            end else begin
                                n_state = wnm_pkg::ST_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            wnm_pkg::ST_READ: begin
                // memory reads at s, s+1 and f land in the read registers
                n_state = wnm_pkg::ST_EVAL;
            end
            wnm_pkg::ST_EVAL: begin
                n_state = wnm_pkg::ST_READ;
                if (in_loop) begin
                    if (r_rd_m == wnm_pkg::CH_STAR) begin
                        if (s_plus1 < r_mask_len && r_rd_m1 == r_rd_n) begin
                            n_ls    = r_s;
                            n_s     = r_s + LW'(2);
                            n_f     = f_plus1;
                            n_lf    = f_plus1;
                            n_saved = 1'b1;
                        end else begin
                            n_f = f_plus1;
                        end
                    end else if (r_rd_m == wnm_pkg::CH_QMARK || r_rd_m == r_rd_n) begin
                        n_s = s_plus1;
                        n_f = f_plus1;
                    end else if (r_saved) begin
                        n_s     = r_ls;
                        n_f     = r_lf;
                        n_saved = 1'b0;
                    end else begin
                        n_match = 1'b0;
                        n_state = wnm_pkg::ST_DONE;
                    end
                end else if (r_s >= r_mask_len && r_f >= r_name_len) begin
                    n_match = 1'b1;
                    n_state = wnm_pkg::ST_DONE;
                end else if (r_s < r_mask_len && r_rd_m == wnm_pkg::CH_STAR &&
                             s_plus1 == r_mask_len) begin
                    n_match = 1'b1;
                    n_state = wnm_pkg::ST_DONE;
                end else if (!r_saved) begin
                    n_match = 1'b0;
                    n_state = wnm_pkg::ST_DONE;
                end else begin
                    n_s     = r_ls;
                    n_f     = r_lf;
                    n_saved = 1'b0;
                end
            end
            wnm_pkg::ST_DONE: begin
                // hold until the output register is free, then empty the name store
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_match = r_match;
                    n_out_trunc = r_ovf;
                    n_name_len  = '0;
                    n_name_dot  = 1'b0;
                    n_ovf       = r_mask_drop;
                    n_state     = wnm_pkg::ST_IDLE;
                end
            end
            default: n_state = wnm_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/wildcard_name_matcher_unit.sv =====
// Wildcard name matcher: checks streamed file names against a DOS-style mask.
// Input requests arrive on the s_axis channel: tuser carries the action (clear
// mask, append mask character, append name character, end name and match) and
// tdata the character. Name characters are folded to upper case on entry.
// Only an end-of-name request produces a result on m_axis: tdata bit 0 is the
// match flag, bit 1 says mask or name characters beyond MAX_LEN were dropped.
// Requests go through a four-entry queue, so the sender keeps streaming while
// a match runs or a result waits in the output register.
// Back end: an append or clear request is handled in the idle state as it is
// popped. An end-of-name request is decided in the idle state, with no walk, for
// the empty, "*.*" and "*." masks; otherwise each step of the walk over the
// stored mask and name passes through a read and an evaluate state, since each
// step reads both character memories through registered ports.
// Reset empties the queue, the mask and the name and clears the truncation
// flag; no clearing pass is needed. While the receiver holds tready low the
// result stays in the output register and the back end stalls on the next
// end-of-name request; s_axis_tready drops once the queue fills.
module wildcard_name_matcher_unit #(
    parameter int MAX_LEN = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] char_code
    input  logic [1:0] s_axis_tuser,    // [1:0] action
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata     // [0] matched, [1] truncated, [7:2] zero
);

    wnm_pkg::t_queue_status status;
    wnm_pkg::t_cmd          push_cmd;
    wnm_pkg::t_cmd          head_cmd;
    logic                   push;
    logic                   pop;

    wnm_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_status      (status),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    wnm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (status)
    );

    wnm_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (head_cmd),
        .i_status      (status),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== rtl/core/wnm_checker.sv =====
module wnm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_rst_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result present right after reset");

    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("request queue not empty after reset");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:2] == 6'b0)
        else $error("result padding bits not zero");

endmodule

bind wildcard_name_matcher_unit wnm_checker u_wnm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
